// ===== design/assert_macros.svh =====
// assertion macros shared by the run merge size tracker rtl
// no dependencies; the assertion bodies drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent holds in a cycle -> consequent holds in the same cycle
`define RMST_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("rmst assertion failed");

// antecedent holds in a cycle -> consequent holds in the next cycle
`define RMST_ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("rmst assertion failed");

`else

`define RMST_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define RMST_ASSERT_NXT(lbl, clk, rst_n, a, b)

`endif

`endif

// ===== design/rmst_pkg.sv =====
// shared types and constants for the run merge size tracker
// used by rmst_ctrl, rmst_dp and run_merge_size_tracker_unit
`timescale 1ns / 1ps

package rmst_pkg;

  // fixed field widths
  localparam int POS_W     = 11;
  localparam int STEP_W    = 11;
  localparam int CNT_OUT_W = 10;
  localparam int LAST_W    = 12;

  typedef logic [1:0] status_t;
  localparam status_t STS_OK    = 2'd0;
  localparam status_t STS_RANGE = 2'd1;
  localparam status_t STS_DUP   = 2'd2;

  typedef logic cfg_idx_t;
  localparam cfg_idx_t REG_POSITIONS = 1'b0;
  localparam cfg_idx_t REG_TARGET    = 1'b1;

  localparam logic [POS_W-1:0] POSITIONS_RESET = 11'd1024;
  localparam logic [POS_W-1:0] TARGET_RESET    = 11'd1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_EVAL,
    S_HL_RD,
    S_HL_WR,
    S_HR_RD,
    S_HR_WR,
    S_HM_RD,
    S_HM_WR,
    S_TGT,
    S_FIN
  } state_t;

  // one strobe per sequencer step
  typedef struct packed {
    logic clear;
    logic load;
    logic rd0;
    logic rd1;
    logic rd2;
    logic eval;
    logic hl_rd;
    logic hl_wr;
    logic hr_rd;
    logic hr_wr;
    logic hm_rd;
    logic hm_wr;
    logic tgt_rd;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic err;
    logic out_free;
  } sts_t;

endpackage

// ===== design/run_merge_size_tracker_unit.sv =====
// top level of the run merge size tracker: sequencer plus datapath
// depends on rmst_pkg, rmst_ctrl, rmst_dp
//
//  port group   dir   transaction carries
//  in_          in    position (1-indexed bit to set)
//  out_         out   step_number, merged_length, target_run_count, latest_step, status
//  cfg_         in    positions_in_use (index 0), target_size (index 1), no wait
//
// a position that gets set goes through the reads, the evaluation and the three
// histogram read-modify-write steps before the next accept; a rejected one skips them.
// after reset a clearing pass wipes the bitmap and all MAX_POSITIONS + 1 histogram
// entries; in_ready stays low until it ends, config writes are taken as ever.
// the result sits in an output register; a stalled out_ side holds the last step.
`timescale 1ns / 1ps

module run_merge_size_tracker_unit #(
  parameter int MAX_POSITIONS = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rmst_pkg::POS_W-1:0]         in_position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rmst_pkg::STEP_W-1:0]        out_step_number,
  output logic [rmst_pkg::POS_W-1:0]         out_merged_length,
  output logic [rmst_pkg::CNT_OUT_W-1:0]     out_target_run_count,
  output logic signed [rmst_pkg::LAST_W-1:0] out_latest_step,
  output rmst_pkg::status_t                  out_status,
  input  logic                               cfg_we,
  input  rmst_pkg::cfg_idx_t                 cfg_index,
  input  logic [rmst_pkg::POS_W-1:0]         cfg_wdata
);
  import rmst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rmst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  rmst_dp #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_position          (in_position),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .out_step_number      (out_step_number),
    .out_merged_length    (out_merged_length),
    .out_target_run_count (out_target_run_count),
    .out_latest_step      (out_latest_step),
    .out_status           (out_status)
  );

endmodule

// ===== design/rmst_ctrl.sv =====
// sequencer for the run merge size tracker: clearing pass, then one transaction
// at a time through the memory steps; depends on rmst_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rmst_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output rmst_pkg::cmd_t cmd,
  input  rmst_pkg::sts_t sts
);
  import rmst_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD0;
        end
      end
      S_RD0: begin
        cmd.rd0   = 1'b1;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.rd1   = 1'b1;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        cmd.rd2   = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        // rejected positions skip the histogram updates
        state_nxt = sts.err ? S_TGT : S_HL_RD;
      end
      S_HL_RD: begin
        cmd.hl_rd = 1'b1;
        state_nxt = S_HL_WR;
      end
      S_HL_WR: begin
        cmd.hl_wr = 1'b1;
        state_nxt = S_HR_RD;
      end
      S_HR_RD: begin
        cmd.hr_rd = 1'b1;
        state_nxt = S_HR_WR;
      end
      S_HR_WR: begin
        cmd.hr_wr = 1'b1;
        state_nxt = S_HM_RD;
      end
      S_HM_RD: begin
        cmd.hm_rd = 1'b1;
        state_nxt = S_HM_WR;
      end
      S_HM_WR: begin
        cmd.hm_wr = 1'b1;
        state_nxt = S_TGT;
      end
      S_TGT: begin
        cmd.tgt_rd = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  `RMST_ASSERT_IMP(a_single_cmd, clk, rst_n, 1'b1, $onehot0(cmd))
  `RMST_ASSERT_NXT(a_accept_starts, clk, rst_n, in_valid && in_ready, state_r == S_RD0)
  `RMST_ASSERT_IMP(a_finish_room, clk, rst_n, cmd.finish, sts.out_free && !in_ready)

endmodule

// ===== design/rmst_dp.sv =====
// datapath for the run merge size tracker: bitmap, run length and histogram
// memories, config registers and result register; depends on rmst_pkg
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rmst_dp #(
  parameter int MAX_POSITIONS = 1024
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  rmst_pkg::cmd_t                          cmd,
  output rmst_pkg::sts_t                          sts,
  input  logic [rmst_pkg::POS_W-1:0]              in_position,
  input  logic                                    cfg_we,
  input  rmst_pkg::cfg_idx_t                      cfg_index,
  input  logic [rmst_pkg::POS_W-1:0]              cfg_wdata,
  input  logic                                    out_ready,
  output logic                                    out_valid,
  output logic [rmst_pkg::STEP_W-1:0]             out_step_number,
  output logic [rmst_pkg::POS_W-1:0]              out_merged_length,
  output logic [rmst_pkg::CNT_OUT_W-1:0]          out_target_run_count,
  output logic signed [rmst_pkg::LAST_W-1:0]      out_latest_step,
  output rmst_pkg::status_t                       out_status
);
  import rmst_pkg::*;

  localparam int LEN_W  = $clog2(MAX_POSITIONS + 1);
  localparam int ADDR_W = $clog2(MAX_POSITIONS);
  localparam int CMP_W  = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam logic [CMP_W-1:0] MAX_C  = CMP_W'(MAX_POSITIONS);
  localparam logic [LEN_W-1:0] MAX_L  = LEN_W'(MAX_POSITIONS);
  localparam logic [LEN_W-1:0] LAST_L = LEN_W'(MAX_POSITIONS - 1);

  // configuration
  logic [POS_W-1:0] positions_r, target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      positions_r <= POSITIONS_RESET;
      target_r    <= TARGET_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_POSITIONS) positions_r <= cfg_wdata;
      if (cfg_index == REG_TARGET)    target_r    <= cfg_wdata;
    end
  end

  logic [CMP_W-1:0] n_eff, p_ext;
  logic             range_c;

  assign n_eff   = (CMP_W'(positions_r) > MAX_C) ? MAX_C : CMP_W'(positions_r);
  assign p_ext   = CMP_W'(in_position);
  assign range_c = (in_position == '0) || (p_ext > n_eff);

  // transaction registers
  logic [ADDR_W-1:0] pos_r;
  logic              range_err_r, dup_r, bm_l_r, tgt_ok_r;
  logic [LEN_W-1:0]  len_l_r, len_r_r;
  logic [LEN_W-1:0]  left_r, right_r, merged_r;
  status_t           status_r;

  // memories and their ports
  logic              bm_mem [MAX_POSITIONS];
  logic              bm_we, bm_wdata, bm_re, bm_q;
  logic [ADDR_W-1:0] bm_waddr, bm_raddr;

  logic [LEN_W-1:0]  len_mem [MAX_POSITIONS];
  logic              len_we, len_re;
  logic [ADDR_W-1:0] len_waddr, len_raddr;
  logic [LEN_W-1:0]  len_q;

  logic [LEN_W-1:0]  hs_mem [MAX_POSITIONS + 1];
  logic              hs_we, hs_re;
  logic [LEN_W-1:0]  hs_waddr, hs_raddr, hs_wdata, hs_q;

  // control registers
  logic [LEN_W-1:0]        clr_r, clr_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [LAST_W-1:0]       last_hit_r, last_hit_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // run ends and target lookup
  logic [ADDR_W-1:0] lo_addr, hi_addr;
  logic              tgt_ok;
  logic [LEN_W-1:0]  tgt_addr;

  assign lo_addr  = ADDR_W'(LEN_W'(pos_r) - left_r);
  assign hi_addr  = ADDR_W'(LEN_W'(pos_r) + right_r);
  assign tgt_ok   = (target_r != '0) && (CMP_W'(target_r) <= MAX_C);
  assign tgt_addr = tgt_ok ? LEN_W'(target_r) : '0;

  // bitmap port selection
  always_comb begin
    bm_re    = cmd.rd0 | cmd.rd1 | cmd.rd2;
    bm_raddr = pos_r;
    if (cmd.rd1) bm_raddr = pos_r - ADDR_W'(1);
    if (cmd.rd2) bm_raddr = pos_r + ADDR_W'(1);
    bm_we    = (cmd.clear && (clr_r < MAX_L)) || cmd.hl_rd;
    bm_waddr = cmd.clear ? clr_r[ADDR_W-1:0] : pos_r;
    bm_wdata = !cmd.clear;
  end

  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    if (bm_re) bm_q <= bm_mem[bm_raddr];
  end

  // run length port selection: neighbours read, both run ends written
  always_comb begin
    len_re    = cmd.rd0 | cmd.rd1;
    len_raddr = cmd.rd1 ? (pos_r + ADDR_W'(1)) : (pos_r - ADDR_W'(1));
    len_we    = cmd.hl_rd | cmd.hl_wr;
    len_waddr = cmd.hl_wr ? hi_addr : lo_addr;
  end

  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_waddr] <= merged_r;
    if (len_re) len_q <= len_mem[len_raddr];
  end

  // histogram read-modify-write: each entry is read, then written back
  always_comb begin
    hs_re    = cmd.hl_rd | cmd.hr_rd | cmd.hm_rd | cmd.tgt_rd;
    hs_raddr = tgt_addr;
    priority if (cmd.hl_rd) hs_raddr = left_r;
    else if (cmd.hr_rd)     hs_raddr = right_r;
    else if (cmd.hm_rd)     hs_raddr = merged_r;
    else                    hs_raddr = tgt_addr;

    hs_we    = 1'b0;
    hs_waddr = clr_r;
    hs_wdata = '0;
    priority if (cmd.clear) begin
      hs_we = 1'b1;
    end else if (cmd.hl_wr) begin
      // decrement held at zero
      hs_we    = (left_r != '0) && (hs_q != '0);
      hs_waddr = left_r;
      hs_wdata = hs_q - LEN_W'(1);
    end else if (cmd.hr_wr) begin
      hs_we    = (right_r != '0) && (hs_q != '0);
      hs_waddr = right_r;
      hs_wdata = hs_q - LEN_W'(1);
    end else if (cmd.hm_wr) begin
      hs_we    = 1'b1;
      hs_waddr = merged_r;
      hs_wdata = hs_q + LEN_W'(1);
    end else begin
      hs_we    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hs_we) hs_mem[hs_waddr] <= hs_wdata;
    if (hs_re) hs_q <= hs_mem[hs_raddr];
  end

  // neighbour evaluation: bm_q carries the right neighbour bit here
  logic [LEN_W-1:0] left_raw, right_raw, right_lim;
  logic [LEN_W-1:0] left_nxt, right_nxt, merged_nxt;
  logic             right_ok;
  status_t          status_nxt;

  always_comb begin
    left_raw   = (bm_l_r && (pos_r != '0)) ? len_l_r : '0;
    left_nxt   = (left_raw > LEN_W'(pos_r)) ? LEN_W'(pos_r) : left_raw;
    right_ok   = bm_q && ((CMP_W'(pos_r) + CMP_W'(1)) < n_eff);
    right_raw  = right_ok ? len_r_r : '0;
    right_lim  = LAST_L - LEN_W'(pos_r);
    right_nxt  = (right_raw > right_lim) ? right_lim : right_raw;
    merged_nxt = LEN_W'(1) + left_nxt + right_nxt;
    priority if (range_err_r) status_nxt = STS_RANGE;
    else if (dup_r)           status_nxt = STS_DUP;
    else                      status_nxt = STS_OK;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r       <= ADDR_W'(p_ext - CMP_W'(1));
      range_err_r <= range_c;
    end
    if (cmd.rd1) begin
      dup_r   <= bm_q;
      len_l_r <= len_q;
    end
    if (cmd.rd2) begin
      bm_l_r  <= bm_q;
      len_r_r <= len_q;
    end
    if (cmd.eval) begin
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      merged_r <= merged_nxt;
      status_r <= status_nxt;
    end
    if (cmd.tgt_rd) tgt_ok_r <= tgt_ok;
  end

  // result assembly
  logic [LEN_W-1:0] tgt_cnt;
  logic             hit;

  assign tgt_cnt = tgt_ok_r ? hs_q : '0;
  assign hit     = (status_r == STS_OK) && (tgt_cnt != '0);

  always_comb begin
    clr_nxt       = cmd.clear ? (clr_r + LEN_W'(1)) : clr_r;
    step_nxt      = cmd.hm_wr ? (step_r + STEP_W'(1)) : step_r;
    last_hit_nxt  = hit ? {1'b0, step_r} : last_hit_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      step_r      <= '0;
      last_hit_r  <= '1;
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.finish) last_hit_r <= last_hit_nxt;
    end
  end

  logic [STEP_W-1:0]    out_step_r;
  logic [POS_W-1:0]     out_merged_r;
  logic [CNT_OUT_W-1:0] out_count_r;
  logic [LAST_W-1:0]    out_latest_r;
  status_t              out_status_r;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_step_r   <= step_r;
      out_merged_r <= (status_r == STS_OK) ? POS_W'(merged_r) : '0;
      out_count_r  <= CNT_OUT_W'(tgt_cnt);
      out_latest_r <= last_hit_nxt;
      out_status_r <= status_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_step_number      = out_step_r;
  assign out_merged_length    = out_merged_r;
  assign out_target_run_count = out_count_r;
  assign out_latest_step      = signed'(out_latest_r);
  assign out_status           = out_status_r;

  assign sts.clr_last = (clr_r == MAX_L);
  assign sts.err      = range_err_r || dup_r;
  assign sts.out_free = !out_valid_r || out_ready;

  `RMST_ASSERT_NXT(a_step_inc, clk, rst_n, cmd.hm_wr, step_r == $past(step_r) + STEP_W'(1))
  `RMST_ASSERT_IMP(a_run_fits, clk, rst_n, cmd.hl_rd, (merged_r <= MAX_L) && (left_r <= LEN_W'(pos_r)))
  `RMST_ASSERT_NXT(a_result_shown, clk, rst_n, cmd.finish, out_valid && (out_status == $past(status_r)))

endmodule
